// File: rtl/binomial_tree_barrier_node_core_defines.svh
// Assertion macros shared by the barrier node checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BINOMIAL_TREE_BARRIER_NODE_CORE_DEFINES_SVH
`define BINOMIAL_TREE_BARRIER_NODE_CORE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define BTB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define BTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/btb_pkg.sv
// Types and constants for the binomial-tree barrier node.
// No dependencies; imported by every module of the block.
package btb_pkg;

    localparam int RANK_W = 8;
    localparam int SIZE_W = 9;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Register indexes, selected by paddr[2].
    localparam logic REG_NODE_RANK  = 1'b0;
    localparam logic REG_GROUP_SIZE = 1'b1;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TOKEN = 1'b1;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [RANK_W-1:0] peer;
    } item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [RANK_W-1:0] target;
        logic              last;
    } result_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_GATHER,
        PH_AWAIT
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_PARENT,
        S_RELEASE,
        S_DONE,
        S_ERROR
    } seq_state_t;

    // What the shared compare unit reports for one tree bit.
    typedef struct packed {
        logic              is_child;
        logic              peer_hit;
        logic              is_hibit;
        logic [RANK_W-1:0] child_rank;
        logic [RANK_W-1:0] parent_rank;
    } step_res_t;

endpackage

// File: rtl/btb_step_unit.sv
// Shared compare unit: evaluates one tree bit position of the node.
// Depends on btb_pkg.
module btb_step_unit #(
    parameter int VW = 9,
    parameter int IW = 3
) (
    input  logic [btb_pkg::RANK_W-1:0] node_rank,
    input  logic [VW-1:0]              size_eff,
    input  logic [btb_pkg::RANK_W-1:0] peer,
    input  logic [IW-1:0]              idx,
    input  logic                       seen,
    output btb_pkg::step_res_t         res
);
    import btb_pkg::*;

    logic [VW-1:0] bit_val;
    logic [VW-1:0] rank_w;
    logic [VW-1:0] peer_w;
    logic [VW-1:0] cand;
    logic [VW-1:0] cleared;
    logic          in_dim;
    logic          rank_bit;

    assign bit_val  = VW'(1) << idx;
    assign rank_w   = VW'(node_rank);
    assign peer_w   = VW'(peer);
    assign cand     = rank_w | bit_val;
    assign cleared  = rank_w & ~bit_val;
    // Bit positions below the tree depth are exactly those with 2^i below the size.
    assign in_dim   = bit_val < size_eff;
    assign rank_bit = |(rank_w & bit_val);

    always_comb
    begin
        res.is_child    = in_dim && !seen && !rank_bit && (cand < size_eff);
        res.peer_hit    = res.is_child && (peer_w == cand);
        res.is_hibit    = in_dim && !seen && rank_bit;
        res.child_rank  = cand[RANK_W-1:0];
        res.parent_rank = cleared[RANK_W-1:0];
    end

endmodule

// File: rtl/binomial_tree_barrier_node_core.sv
// One node of a binomial-tree barrier. A start or a peer token is taken when item_ready is
// high; the node then walks its LOG_NODES tree bits from the top down, one bit a cycle through
// a shared compare unit, to find its children, its parent and whether the token matches, and
// decides in a separate step, S_DECIDE, before any result leaves.
// Results leave at most one a cycle. A release walks the tree bits again upwards, one a cycle
// unless a send to a child is stalled, sending to each child in ascending rank, and ends with
// the completion result. A result that waits for the receiver holds the sequencer, and so the
// input, until it is taken.
// Depends on btb_pkg and btb_step_unit.
module binomial_tree_barrier_node_core #(
    parameter int MAX_NODES = 256,
    parameter int LOG_NODES = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  btb_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output btb_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [btb_pkg::ADDR_W-1:0] paddr,
    input  logic [btb_pkg::DATA_W-1:0] pwdata,
    output logic [btb_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import btb_pkg::*;

    localparam int SZ_W  = $clog2(MAX_NODES + 1);
    localparam int VW_A  = (SZ_W > SIZE_W) ? SZ_W : SIZE_W;
    localparam int VW    = (VW_A > LOG_NODES + 1) ? VW_A : LOG_NODES + 1;
    localparam int IW    = (LOG_NODES > 1) ? $clog2(LOG_NODES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(LOG_NODES - 1);

    seq_state_t             state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [LOG_NODES-1:0]   children_reg, children_next;
    logic                   parent_arr_reg, parent_arr_next;
    logic [RANK_W-1:0]      node_rank_reg, node_rank_next;
    logic [SIZE_W-1:0]      group_size_reg, group_size_next;
    logic                   mode_reg, mode_next;
    logic [RANK_W-1:0]      peer_reg, peer_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic                   seen_reg, seen_next;
    logic [LOG_NODES-1:0]   childmask_reg, childmask_next;
    logic [LOG_NODES-1:0]   hitmask_reg, hitmask_next;
    logic [RANK_W-1:0]      parent_rank_reg, parent_rank_next;
    logic                   result_valid_reg, result_valid_next;
    result_t                result_reg, result_next;

    logic [VW-1:0]          size_eff;
    step_res_t              step;
    logic                   out_free;
    logic                   cfg_write;

    always_comb
    begin
        if (group_size_reg == '0)
            size_eff = VW'(1);
        else if (VW'(group_size_reg) > VW'(MAX_NODES))
            size_eff = VW'(MAX_NODES);
        else
            size_eff = VW'(group_size_reg);
    end

    btb_step_unit #(
        .VW (VW),
        .IW (IW)
    ) u_step (
        .node_rank (node_rank_reg),
        .size_eff  (size_eff),
        .peer      (peer_reg),
        .idx       (idx_reg),
        .seen      (seen_reg),
        .res       (step)
    );

    assign out_free     = !result_valid_reg || result_ready;
    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[2] == REG_GROUP_SIZE)
            prdata = DATA_W'(group_size_reg);
        else
            prdata = DATA_W'(node_rank_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_IDLE;
            children_reg     <= '0;
            parent_arr_reg   <= 1'b0;
            node_rank_reg    <= '0;
            group_size_reg   <= SIZE_W'(1);
            mode_reg         <= MODE_START;
            peer_reg         <= '0;
            idx_reg          <= '0;
            seen_reg         <= 1'b0;
            childmask_reg    <= '0;
            hitmask_reg      <= '0;
            parent_rank_reg  <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            children_reg     <= children_next;
            parent_arr_reg   <= parent_arr_next;
            node_rank_reg    <= node_rank_next;
            group_size_reg   <= group_size_next;
            mode_reg         <= mode_next;
            peer_reg         <= peer_next;
            idx_reg          <= idx_next;
            seen_reg         <= seen_next;
            childmask_reg    <= childmask_next;
            hitmask_reg      <= hitmask_next;
            parent_rank_reg  <= parent_rank_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    always_comb
    begin
        logic                 root;
        logic                 parent_match;
        logic                 matched;
        logic                 send_parent;
        phase_t               ph;
        logic [LOG_NODES-1:0] ch;
        logic                 pa;

        state_next        = state_reg;
        phase_next        = phase_reg;
        children_next     = children_reg;
        parent_arr_next   = parent_arr_reg;
        node_rank_next    = node_rank_reg;
        group_size_next   = group_size_reg;
        mode_next         = mode_reg;
        peer_next         = peer_reg;
        idx_next          = idx_reg;
        seen_next         = seen_reg;
        childmask_next    = childmask_reg;
        hitmask_next      = hitmask_reg;
        parent_rank_next  = parent_rank_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;

        root         = !seen_reg;
        parent_match = !root && (peer_reg == parent_rank_reg);
        matched      = (|hitmask_reg) || parent_match;
        send_parent  = 1'b0;
        ph           = phase_reg;
        ch           = children_reg;
        pa           = parent_arr_reg;

        if (cfg_write)
        begin
            if (paddr[2] == REG_GROUP_SIZE)
                group_size_next = pwdata[SIZE_W-1:0];
            else
                node_rank_next = pwdata[RANK_W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    mode_next        = item.mode;
                    peer_next        = item.peer;
                    idx_next         = LAST_IDX;
                    seen_next        = 1'b0;
                    childmask_next   = '0;
                    hitmask_next     = '0;
                    parent_rank_next = '0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Top-down walk: the first set rank bit met is the highest one.
                if (step.is_child)
                    childmask_next[idx_reg] = 1'b1;
                if (step.peer_hit)
                    hitmask_next[idx_reg] = 1'b1;
                if (step.is_hibit)
                begin
                    seen_next        = 1'b1;
                    parent_rank_next = step.parent_rank;
                end
                if (idx_reg == '0)
                    state_next = S_DECIDE;
                else
                    idx_next = idx_reg - IW'(1);
            end
            S_DECIDE:
            begin
                if (mode_reg == MODE_TOKEN && !matched)
                begin
                    state_next = S_ERROR;
                end
                else
                begin
                    if (mode_reg == MODE_START)
                    begin
                        if (ph == PH_IDLE)
                            ph = PH_GATHER;
                    end
                    else
                    begin
                        ch = ch | hitmask_reg;
                        if (hitmask_reg == '0)
                            pa = 1'b1;
                    end
                    if (ph == PH_GATHER && (ch & childmask_reg) == childmask_reg)
                    begin
                        ph = PH_AWAIT;
                        if (root)
                            pa = 1'b1;
                        else
                            send_parent = 1'b1;
                    end
                    phase_next      = ph;
                    children_next   = ch;
                    parent_arr_next = pa;
                    idx_next        = '0;
                    if (send_parent)
                        state_next = S_PARENT;
                    else if (ph == PH_AWAIT && pa)
                        state_next = S_RELEASE;
                    else
                        state_next = S_IDLE;
                end
            end
            S_PARENT:
            begin
                if (out_free)
                begin
                    result_valid_next  = 1'b1;
                    result_next.kind   = KIND_SEND;
                    result_next.target = parent_rank_reg;
                    result_next.last   = !parent_arr_reg;
                    state_next         = parent_arr_reg ? S_RELEASE : S_IDLE;
                end
            end
            S_RELEASE:
            begin
                if (!childmask_reg[idx_reg] || out_free)
                begin
                    if (childmask_reg[idx_reg])
                    begin
                        result_valid_next  = 1'b1;
                        result_next.kind   = KIND_SEND;
                        result_next.target = step.child_rank;
                        result_next.last   = 1'b0;
                    end
                    if (idx_reg == LAST_IDX)
                        state_next = S_DONE;
                    else
                        idx_next = idx_reg + IW'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next  = 1'b1;
                    result_next.kind   = KIND_DONE;
                    result_next.target = '0;
                    result_next.last   = 1'b1;
                    phase_next         = PH_IDLE;
                    children_next      = '0;
                    parent_arr_next    = 1'b0;
                    state_next         = S_IDLE;
                end
            end
            S_ERROR:
            begin
                if (out_free)
                begin
                    result_valid_next  = 1'b1;
                    result_next.kind   = KIND_ERR;
                    result_next.target = peer_reg;
                    result_next.last   = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/btb_checker.sv
// Port-level checks for the barrier node, bound to the top level.
// Depends on btb_pkg and binomial_tree_barrier_node_core_defines.svh.
`include "binomial_tree_barrier_node_core_defines.svh"

module btb_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_ready,
    input  logic             result_valid,
    input  logic             result_ready,
    input  btb_pkg::result_t result
);
    import btb_pkg::*;

    // A stalled result transfer keeps its payload.
    `BTB_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

    // The node works on one item at a time.
    `BTB_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "item taken while busy")

    // An unexpected peer always ends the results of its item.
    `BTB_ASSERT_SAME(a_err_last, result_valid && result.kind == KIND_ERR, result.last, "error result not last")

    // Completion is the final result and names no rank.
    `BTB_ASSERT_SAME(a_done_last, result_valid && result.kind == KIND_DONE, result.last && result.target == '0, "bad completion result")

endmodule

bind binomial_tree_barrier_node_core btb_checker u_btb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
